// ===== rtl/chip8_cpu_core_macros.svh =====
// Assertion macros for the CHIP-8 core.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef CHIP8_CPU_CORE_MACROS_SVH
`define CHIP8_CPU_CORE_MACROS_SVH

// Condition holds at every edge out of reset.
`define C8_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define C8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/c8_pkg.sv =====
// Shared constants, types and helpers of the CHIP-8 core.
// No dependencies.
package c8_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int SW = $clog2(STACK_DEPTH);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OVER   = 3'd1;
  localparam logic [2:0] ST_UNDER  = 3'd2;
  localparam logic [2:0] ST_UNIMPL = 3'd3;
  localparam logic [2:0] ST_HALTED = 3'd4;

  localparam logic [AW-1:0] BOOT_PC   = 12'h200;
  localparam logic [15:0]   FONT_BASE = 16'h0050;
  localparam logic [15:0]   INST_CLS  = 16'h00E0;
  localparam logic [15:0]   INST_RET  = 16'h00EE;

  localparam logic [7:0] FN_KEY_DOWN = 8'h9E;
  localparam logic [7:0] FN_KEY_UP   = 8'hA1;
  localparam logic [7:0] FN_GET_DT   = 8'h07;
  localparam logic [7:0] FN_SET_DT   = 8'h15;
  localparam logic [7:0] FN_SET_ST   = 8'h18;
  localparam logic [7:0] FN_ADD_I    = 8'h1E;
  localparam logic [7:0] FN_FONT     = 8'h29;
  localparam logic [7:0] FN_BCD      = 8'h33;
  localparam logic [7:0] FN_STORE    = 8'h55;
  localparam logic [7:0] FN_LOAD     = 8'h65;

  typedef struct packed {
    logic                    clr;
    logic                    wr_en;
    logic [RW-1:0]           row;
    logic [SCREEN_WIDTH-1:0] wdata;
  } fr_req_t;

  // Decimal digit of v: sel 0 hundreds, 1 tens, 2 ones.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - 8'(h) * 8'd100;
    p = 15'(r[6:0]) * 15'd205;
    t = p[14:11];
    o = r - 8'(t) * 8'd10;
    case (sel)
      2'd0:    bcd_digit = {6'd0, h};
      2'd1:    bcd_digit = {4'd0, t};
      default: bcd_digit = o;
    endcase
  endfunction

endpackage

// ===== rtl/c8_frame.sv =====
// Display frame store: 32 rows of 64 pixels, one row read or written per cycle.
// Depends on c8_pkg.
module c8_frame (
  input  logic                            clk,
  input  logic                            rst_n,
  input  c8_pkg::fr_req_t                 req,
  output logic [c8_pkg::SCREEN_WIDTH-1:0] rd_data
);

  logic [c8_pkg::SCREEN_WIDTH-1:0]  mem [c8_pkg::SCREEN_HEIGHT];
  logic [c8_pkg::SCREEN_HEIGHT-1:0] vld_r;
  logic [c8_pkg::SCREEN_WIDTH-1:0]  q_r;
  logic                             qv_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.row] <= req.wdata;
    end
    q_r <= mem[req.row];
  end

  // A row never written since reset or clear reads as blank.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      qv_r <= vld_r[req.row];
      if (req.wr_en) begin
        vld_r[req.row] <= 1'b1;
      end
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

// ===== rtl/chip8_cpu_core.sv =====
// CHIP-8 core: input items load memory, execute one instruction, or read a display row.
// Depends on c8_pkg, c8_frame and chip8_cpu_core_macros.svh.
//
// Use: one input channel (in_valid / in_stall) and one result channel
// (out_valid / out_stall). Every input transfer yields exactly one result.
// Execute: plain instructions fetch two bytes, read VX and VY from the register
// file and execute, and a flag write follows where one is due; DXYN then reads
// and writes the display once per sprite row and writes VF, FX33 writes three
// digits, and FX55/FX65 read and write once per register. The longest items
// are DXYF and FX65 with X=F.
// A new item is taken while a result still waits in the output register; the
// core then holds its finished result until out_stall drops.
// Reset: PC 0x200, registers, index, timers and stack level zero, display
// blank, not halted. Program memory is undefined until written.
// Halt: after a stack fault or a machine routine call the core stops
// executing and every result reports the halted status.
module chip8_cpu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_key_mask,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [11:0] out_program_counter,
  output logic [63:0] out_row_pixels,
  output logic [7:0]  out_sound_level,
  output logic [7:0]  out_delay_level
);

  `include "chip8_cpu_core_macros.svh"

  localparam int AW = c8_pkg::AW;

  typedef enum logic [4:0] {
    S_IDLE, S_ROW, S_F1, S_F2, S_RX, S_RY, S_EXEC, S_WB,
    S_DRD, S_DWR, S_DFIN, S_BCD, S_SRD, S_SWR, S_LRD, S_LWR, S_DONE
  } state_t;

  state_t state_r;

  logic [7:0]  mem [c8_pkg::MEM_BYTES];
  logic [7:0]  mem_q_r;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [7:0]  mem_wd;
  logic        mem_we;

  logic [7:0]  vmem [16];
  logic [15:0] vvld_r;
  logic [7:0]  v_q_r;
  logic        v_qv_r;
  logic [3:0]  v_ra, v_wa;
  logic [7:0]  v_wd, vq;
  logic        v_we;

  logic [AW-1:0] stk_r [c8_pkg::STACK_DEPTH];
  logic [c8_pkg::SW:0] sp_r;

  logic [AW-1:0] pc_r;
  logic [15:0] idx_r, inst_r, key_r;
  logic [7:0]  vx_r, vy_r, rnd_r, dt_r, st_r, flag_r;
  logic [3:0]  cnt_r;
  logic        col_r, halted_r;
  logic [2:0]  status_r;
  logic [63:0] row_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [11:0] out_pc_r;
  logic [63:0] out_row_r;
  logic [7:0]  out_st_r, out_dt_r;

  c8_pkg::fr_req_t fr_req;
  logic [63:0] fr_q;

  logic        in_acc;
  logic [3:0]  ix, iy, in_n, top;
  logic [7:0]  nn;
  logic [AW-1:0] nnn, pc_next, pc_skip, i_addr;
  logic [8:0]  sum9;
  logic [7:0]  ex_res, ex_flag;
  logic        ex_we, ex_fwe;
  logic [5:0]  draw_row;
  logic [63:0] spr;

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign top  = inst_r[15:12];
  assign ix   = inst_r[11:8];
  assign iy   = inst_r[7:4];
  assign in_n = inst_r[3:0];
  assign nn   = inst_r[7:0];
  assign nnn  = inst_r[11:0];
  assign pc_next = pc_r + AW'(2);
  assign pc_skip = pc_r + AW'(4);
  assign i_addr  = idx_r[AW-1:0] + AW'(cnt_r);
  assign sum9 = {1'b0, vx_r} + {1'b0, vy_r};
  assign vq = v_qv_r ? v_q_r : 8'd0;
  assign draw_row = {1'b0, vy_r[c8_pkg::RW-1:0]} + {2'd0, cnt_r};
  assign spr = {mem_q_r, 56'd0} >> vx_r[c8_pkg::XW-1:0];

  // Register-file result and flag of the instruction in S_EXEC; flag write follows in S_WB.
  always_comb begin
    ex_res  = 8'd0;
    ex_flag = 8'd0;
    ex_we   = 1'b0;
    ex_fwe  = 1'b0;
    case (top)
      4'h6: begin ex_we = 1'b1; ex_res = nn; end
      4'h7: begin ex_we = 1'b1; ex_res = vx_r + nn; end
      4'h8: begin
        ex_we = 1'b1;
        case (in_n)
          4'h0: ex_res = vy_r;
          4'h1: ex_res = vx_r | vy_r;
          4'h2: ex_res = vx_r & vy_r;
          4'h3: ex_res = vx_r ^ vy_r;
          4'h4: begin ex_res = sum9[7:0]; ex_fwe = 1'b1; ex_flag = {7'd0, sum9[8]}; end
          4'h5: begin ex_res = vx_r - vy_r; ex_fwe = 1'b1; ex_flag = {7'd0, vx_r >= vy_r}; end
          4'h6: begin ex_res = vx_r >> 1; ex_fwe = 1'b1; ex_flag = {7'd0, vx_r[0]}; end
          4'h7: begin ex_res = vy_r - vx_r; ex_fwe = 1'b1; ex_flag = {7'd0, vy_r >= vx_r}; end
          4'hE: begin ex_res = vx_r << 1; ex_fwe = 1'b1; ex_flag = {7'd0, vx_r[7]}; end
          default: ex_we = 1'b0;
        endcase
      end
      4'hC: begin ex_we = 1'b1; ex_res = rnd_r & nn; end
      4'hF: begin ex_we = (nn == c8_pkg::FN_GET_DT); ex_res = dt_r; end
      default: ;
    endcase
    // With X = F the result overwrites the flag, so drop the flag write.
    if (ix == 4'hF) begin
      ex_fwe = 1'b0;
    end
  end

  // Memory, register file and frame port control.
  always_comb begin
    mem_ra = pc_r;
    mem_we = 1'b0;
    mem_wa = i_addr;
    mem_wd = vq;
    v_ra   = ix;
    v_we   = 1'b0;
    v_wa   = ix;
    v_wd   = ex_res;
    fr_req.clr   = 1'b0;
    fr_req.wr_en = 1'b0;
    fr_req.row   = draw_row[c8_pkg::RW-1:0];
    fr_req.wdata = fr_q ^ spr;
    unique case (state_r)
      S_IDLE: begin
        mem_we = in_acc && (in_opcode == c8_pkg::OP_WRITE);
        mem_wa = in_address;
        mem_wd = in_data_byte;
        fr_req.row = in_address[c8_pkg::RW-1:0];
      end
      S_F1: mem_ra = pc_r + AW'(1);
      S_F2: v_ra = (inst_r[15:12] == 4'hB) ? 4'd0 : inst_r[11:8];
      S_RX: v_ra = iy;
      S_EXEC: begin
        v_we = ex_we;
        fr_req.clr = (inst_r == c8_pkg::INST_CLS);
      end
      S_WB: begin v_we = 1'b1; v_wa = 4'hF; v_wd = flag_r; end
      S_DRD: mem_ra = i_addr;
      S_DWR: fr_req.wr_en = 1'b1;
      S_DFIN: begin v_we = 1'b1; v_wa = 4'hF; v_wd = {7'd0, col_r}; end
      S_BCD: begin mem_we = 1'b1; mem_wd = c8_pkg::bcd_digit(vx_r, cnt_r[1:0]); end
      S_SRD: v_ra = cnt_r;
      S_SWR: mem_we = 1'b1;
      S_LRD: mem_ra = i_addr;
      S_LWR: begin v_we = 1'b1; v_wa = cnt_r; v_wd = mem_q_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
    if (v_we) begin
      vmem[v_wa] <= v_wd;
    end
    v_q_r <= vmem[v_ra];
  end

  c8_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (fr_req),
    .rd_data (fr_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vvld_r      <= '0;
      v_qv_r      <= 1'b0;
      idx_r       <= '0;
      pc_r        <= c8_pkg::BOOT_PC;
      sp_r        <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_qv_r <= vvld_r[v_ra];
      if (v_we) begin
        vvld_r[v_wa] <= 1'b1;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            status_r <= halted_r ? c8_pkg::ST_HALTED : c8_pkg::ST_OK;
            row_r    <= '0;
            key_r    <= in_key_mask;
            rnd_r    <= in_random_byte;
            if (in_opcode == c8_pkg::OP_ROW) begin
              state_r <= S_ROW;
            end else if (in_opcode == c8_pkg::OP_EXEC && !halted_r) begin
              state_r <= S_F1;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_ROW: begin row_r <= fr_q; state_r <= S_DONE; end
        S_F1: begin inst_r[15:8] <= mem_q_r; state_r <= S_F2; end
        S_F2: begin inst_r[7:0] <= mem_q_r; state_r <= S_RX; end
        S_RX: begin vx_r <= vq; state_r <= S_RY; end
        S_RY: begin vy_r <= vq; state_r <= S_EXEC; end
        S_EXEC: begin
          pc_r    <= pc_next;
          flag_r  <= ex_flag;
          cnt_r   <= '0;
          col_r   <= 1'b0;
          state_r <= ex_fwe ? S_WB : S_DONE;
          case (top)
            4'h0: begin
              if (inst_r == c8_pkg::INST_RET) begin
                if (sp_r == '0) begin
                  pc_r <= pc_r; halted_r <= 1'b1; status_r <= c8_pkg::ST_UNDER;
                end else begin
                  sp_r <= sp_r - 1'b1;
                  pc_r <= stk_r[c8_pkg::SW'(sp_r - 1'b1)];
                end
              end else if (inst_r != c8_pkg::INST_CLS) begin
                pc_r <= pc_r; halted_r <= 1'b1; status_r <= c8_pkg::ST_UNIMPL;
              end
            end
            4'h1: pc_r <= nnn;
            4'h2: begin
              if (sp_r >= (c8_pkg::SW+1)'(c8_pkg::STACK_DEPTH)) begin
                pc_r <= pc_r; halted_r <= 1'b1; status_r <= c8_pkg::ST_OVER;
              end else begin
                stk_r[sp_r[c8_pkg::SW-1:0]] <= pc_next;
                sp_r <= sp_r + 1'b1;
                pc_r <= nnn;
              end
            end
            4'h3: if (vx_r == nn) pc_r <= pc_skip;
            4'h4: if (vx_r != nn) pc_r <= pc_skip;
            4'h5: if (vx_r == vy_r) pc_r <= pc_skip;
            4'h9: if (vx_r != vy_r) pc_r <= pc_skip;
            4'hA: idx_r <= {4'd0, nnn};
            4'hB: pc_r <= AW'(vx_r) + nnn;
            4'hD: state_r <= S_DRD;
            4'hE: begin
              if ((nn == c8_pkg::FN_KEY_DOWN && key_r[vx_r[3:0]]) ||
                  (nn == c8_pkg::FN_KEY_UP && !key_r[vx_r[3:0]])) begin
                pc_r <= pc_skip;
              end
            end
            4'hF: begin
              case (nn)
                c8_pkg::FN_SET_DT: dt_r <= vx_r;
                c8_pkg::FN_SET_ST: st_r <= vx_r;
                c8_pkg::FN_ADD_I:  idx_r <= idx_r + {8'd0, vx_r};
                c8_pkg::FN_FONT:   idx_r <= c8_pkg::FONT_BASE + {6'd0, vx_r, 2'd0} + {8'd0, vx_r};
                c8_pkg::FN_BCD:    state_r <= S_BCD;
                c8_pkg::FN_STORE:  state_r <= S_SRD;
                c8_pkg::FN_LOAD:   state_r <= S_LRD;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_WB: state_r <= S_DONE;
        S_DRD: begin
          // Stop at the last sprite row or at the bottom edge.
          state_r <= (cnt_r == in_n || draw_row[5]) ? S_DFIN : S_DWR;
        end
        S_DWR: begin
          col_r   <= col_r | (|(fr_q & spr));
          cnt_r   <= cnt_r + 1'b1;
          state_r <= S_DRD;
        end
        S_DFIN: state_r <= S_DONE;
        S_BCD: begin
          cnt_r   <= cnt_r + 1'b1;
          state_r <= (cnt_r == 4'd2) ? S_DONE : S_BCD;
        end
        S_SRD: state_r <= S_SWR;
        S_SWR: begin
          cnt_r   <= cnt_r + 1'b1;
          state_r <= (cnt_r == ix) ? S_DONE : S_SRD;
        end
        S_LRD: state_r <= S_LWR;
        S_LWR: begin
          cnt_r   <= cnt_r + 1'b1;
          state_r <= (cnt_r == ix) ? S_DONE : S_LRD;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_pc_r     <= pc_r;
            out_row_r    <= row_r;
            out_st_r     <= st_r;
            out_dt_r     <= dt_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_program_counter = out_pc_r;
  assign out_row_pixels      = out_row_r;
  assign out_sound_level     = out_st_r;
  assign out_delay_level     = out_dt_r;

  `C8_ASSERT_ALWAYS(a_sp_range, sp_r <= (c8_pkg::SW+1)'(c8_pkg::STACK_DEPTH), "stack level out of range")
  `C8_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt flag cleared")
  `C8_ASSERT_ALWAYS(a_fr_excl, !(fr_req.clr && fr_req.wr_en), "frame clear during row write")

endmodule
